### rtl/ucd_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared types, constants and decode helpers for the UTF-8 to code point
// decoder and its submodules.
// ----------------------------------------------------------------------------
package ucd_pkg;

   // Field widths of the streams.
   localparam int BYTE_W     = 8;
   localparam int CP_W       = 21;
   localparam int RSP_DATA_W = 24;

   // Depth of the result queue; an item is decoded only while two entries are free.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Code points that pass the control character filter.
   localparam logic [CP_W-1:0] CP_MIN_PRINT = 21'd32;
   localparam logic [CP_W-1:0] CP_TAB       = 21'd9;

   // What a byte announces when it stands where a lead is expected.
   typedef enum logic [2:0] {
      LEAD_BAD,
      LEAD_ONE,
      LEAD_TWO,
      LEAD_THREE,
      LEAD_FOUR
   } lead_type;

   // One result word as it waits in the queue.
   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            run_last;
   } rsp_entry_type;

   // Results that one decoded byte hands to the queue.
   typedef struct packed {
      logic [1:0]    count;
      rsp_entry_type first;
      rsp_entry_type second;
   } push_type;

   // Classify a byte by its leading bits.
   function automatic lead_type lead_kind(input logic [BYTE_W-1:0] b);
      lead_type kind;
      priority if (b[7] == 1'b0)             kind = LEAD_ONE;
      else if (b[7:5] == 3'b110)             kind = LEAD_TWO;
      else if (b[7:4] == 4'b1110)            kind = LEAD_THREE;
      else if (b[7:3] == 5'b11110)           kind = LEAD_FOUR;
      else                                   kind = LEAD_BAD;
      return kind;
   endfunction

   // A code point is delivered if it is printable or a tab.
   function automatic logic keep_cp(input logic [CP_W-1:0] cp);
      return (cp >= CP_MIN_PRINT) || (cp == CP_TAB);
   endfunction

   // Build a code point from the held bytes and the final byte.
   // held is the number of bytes held before the final one, lead included.
   function automatic logic [CP_W-1:0] assemble(input logic [BYTE_W-1:0] h0,
                                                input logic [BYTE_W-1:0] h1,
                                                input logic [BYTE_W-1:0] h2,
                                                input logic [BYTE_W-1:0] b,
                                                input logic [1:0]        held);
      logic [CP_W-1:0] cp;
      unique case (held)
         2'd1: cp = {10'd0, h0[4:0], b[5:0]};
         2'd2: cp = {5'd0, h0[3:0], h1[5:0], b[5:0]};
         2'd3: cp = {h0[2:0], h1[5:0], h2[5:0], b[5:0]};
         default: cp = {13'd0, b};
      endcase
      return cp;
   endfunction

endpackage

### rtl/utf8_to_codepoint_decoder_top.sv
// ----------------------------------------------------------------------------
// UTF-8 to code point decoder
// Lenient UTF-8 byte stream decoder that emits 21-bit code points.
// ----------------------------------------------------------------------------
// Usage:
// The request stream carries one byte per word on req_tdata, with req_tlast
// marking the last byte of a buffer. The response stream carries one code
// point per word on rsp_tdata; rsp_tlast marks the last word that a given
// byte produced. A byte may produce no word (lead, trailing, stray or
// filtered control byte), one word, or two words when a buffer ends in the
// middle of a sequence and the bytes after the dropped lead decode again.
// An accepted byte passes from the input register through the single-pass
// decode into the result queue, and its first word is offered from the
// head of that queue.
// Throughput: one byte per cycle, set by the single-pass decode between the
// input register and a four-entry result queue. A byte is decoded only while
// the queue holds at most two words, so the queue absorbs the extra word of
// a two-word byte; the input waits only when three or more words are
// still queued.
// When the receiver stalls, the queue fills and req_tready drops once the
// input register holds a byte that cannot be decoded yet; nothing is lost.
// Reset clears the pending sequence, the input register and the queue.
// ----------------------------------------------------------------------------
module utf8_to_codepoint_decoder_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] byte_in
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ucd_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [20:0] code_point, rest zero
   output logic                              rsp_tlast
);

   logic                       in_valid_ff;
   logic [ucd_pkg::BYTE_W-1:0] in_byte_ff;
   logic                       in_end_ff;
   logic                       space_ok;
   logic                       advance;
   ucd_pkg::push_type          push;
   ucd_pkg::rsp_entry_type     head;

   // The staged byte is decoded when the queue has room for two words.
   assign advance    = in_valid_ff && space_ok;
   assign req_tready = !in_valid_ff || space_ok;

   // Input register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
   end

   ucd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .byte_in    (in_byte_ff),
      .buffer_end (in_end_ff),
      .push       (push)
   );

   ucd_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .space_ok   (space_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .head       (head)
   );

   // Response word packing.
   assign rsp_tdata = {{(ucd_pkg::RSP_DATA_W - ucd_pkg::CP_W){1'b0}}, head.code_point};
   assign rsp_tlast = head.run_last;

endmodule

### rtl/ucd_decode.sv
// ----------------------------------------------------------------------------
// UTF-8 decode stage
// Holds the partial sequence and turns the staged byte into zero to two
// result words in one pass, including the replay at a buffer end.
// ----------------------------------------------------------------------------
module ucd_decode (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [ucd_pkg::BYTE_W-1:0]   byte_in,
   input  logic                         buffer_end,
   output ucd_pkg::push_type            push
);

   // Sequence state: held bytes carry no reset, the counts do.
   logic [ucd_pkg::BYTE_W-1:0] held0_ff, held1_ff, held2_ff;
   logic [ucd_pkg::BYTE_W-1:0] held0_in, held1_in, held2_in;
   logic [1:0]                 held_count_ff, held_count_in;
   logic [1:0]                 needed_ff, needed_in;

   ucd_pkg::lead_type          kind;
   ucd_pkg::lead_type          kind_a;
   ucd_pkg::lead_type          kind_b;
   logic [ucd_pkg::BYTE_W-1:0] replay_a;
   logic [ucd_pkg::CP_W-1:0]   cp0, cp1;
   logic                       v0, v1;

   // Decode the staged byte against the held sequence.
   always_comb begin
      held0_in      = held0_ff;
      held1_in      = held1_ff;
      held2_in      = held2_ff;
      held_count_in = held_count_ff;
      needed_in     = needed_ff;
      cp0           = '0;
      cp1           = '0;
      v0            = 1'b0;
      v1            = 1'b0;
      kind          = ucd_pkg::lead_kind(byte_in);
      replay_a      = held1_ff;
      kind_a        = ucd_pkg::lead_kind(replay_a);
      kind_b        = kind;

      if (needed_ff == 2'd0) begin
         // Idle: a byte here is a lead, an ASCII byte or a stray byte.
         unique case (kind)
            ucd_pkg::LEAD_ONE: begin
               cp0 = {13'd0, byte_in};
               v0  = ucd_pkg::keep_cp(cp0);
            end
            ucd_pkg::LEAD_TWO, ucd_pkg::LEAD_THREE, ucd_pkg::LEAD_FOUR: begin
               if (!buffer_end) begin
                  held0_in      = byte_in;
                  held_count_in = 2'd1;
                  unique case (kind)
                     ucd_pkg::LEAD_TWO:   needed_in = 2'd1;
                     ucd_pkg::LEAD_THREE: needed_in = 2'd2;
                     default:             needed_in = 2'd3;
                  endcase
               end
            end
            default: ;
         endcase
      end else if (needed_ff == 2'd1) begin
         // Final trailing byte completes the sequence.
         cp0           = ucd_pkg::assemble(held0_ff, held1_ff, held2_ff, byte_in,
                                           held_count_ff);
         v0            = ucd_pkg::keep_cp(cp0);
         held_count_in = 2'd0;
         needed_in     = 2'd0;
      end else if (buffer_end) begin
         // Buffer ends early: drop the lead and decode what follows it again.
         held_count_in = 2'd0;
         needed_in     = 2'd0;
         if (held_count_ff == 2'd2) begin
            if (kind_a == ucd_pkg::LEAD_ONE) begin
               cp0 = {13'd0, replay_a};
               v0  = ucd_pkg::keep_cp(cp0);
               if (kind_b == ucd_pkg::LEAD_ONE) begin
                  cp1 = {13'd0, byte_in};
                  v1  = ucd_pkg::keep_cp(cp1);
               end
            end else if (kind_a == ucd_pkg::LEAD_TWO) begin
               cp0 = {10'd0, replay_a[4:0], byte_in[5:0]};
               v0  = ucd_pkg::keep_cp(cp0);
            end else if (kind_b == ucd_pkg::LEAD_ONE) begin
               cp1 = {13'd0, byte_in};
               v1  = ucd_pkg::keep_cp(cp1);
            end
         end else if (kind_b == ucd_pkg::LEAD_ONE) begin
            cp0 = {13'd0, byte_in};
            v0  = ucd_pkg::keep_cp(cp0);
         end
      end else begin
         // Another trailing byte: keep it and wait for the rest.
         unique case (held_count_ff)
            2'd1:    held1_in = byte_in;
            2'd2:    held2_in = byte_in;
            default: ;
         endcase
         held_count_in = held_count_ff + 2'd1;
         needed_in     = needed_ff - 2'd1;
      end
   end

   // Pack the surviving results; the last one carries the run marker.
   always_comb begin
      push = '0;
      if (v0 && v1) begin
         push.count             = 2'd2;
         push.first.code_point  = cp0;
         push.first.run_last    = 1'b0;
         push.second.code_point = cp1;
         push.second.run_last   = 1'b1;
      end else if (v0 || v1) begin
         push.count            = 2'd1;
         push.first.code_point = v0 ? cp0 : cp1;
         push.first.run_last   = 1'b1;
      end
      if (!advance) begin
         push.count = 2'd0;
      end
   end

   // Sequence counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= 2'd0;
         needed_ff     <= 2'd0;
      end else if (advance) begin
         held_count_ff <= held_count_in;
         needed_ff     <= needed_in;
      end
   end

   // Held bytes.
   always_ff @(posedge clock) begin
      if (advance) begin
         held0_ff <= held0_in;
         held1_ff <= held1_in;
         held2_ff <= held2_in;
      end
   end

   // A pending sequence always holds its lead, and lead plus missing bytes fit.
   a_held_lead: assert property (@(posedge clock) disable iff (reset)
      (needed_ff != 2'd0) |-> (held_count_ff != 2'd0))
      else $error("sequence pending without a held lead");

   a_seq_len: assert property (@(posedge clock) disable iff (reset)
      (needed_ff != 2'd0) |->
         (({1'b0, held_count_ff} + {1'b0, needed_ff}) >= 3'd2) &&
         (({1'b0, held_count_ff} + {1'b0, needed_ff}) <= 3'd4))
      else $error("held and missing bytes do not form a valid sequence");

endmodule

### rtl/ucd_rsp_queue.sv
// ----------------------------------------------------------------------------
// Result queue
// Small shift queue that takes up to two result words per cycle and hands
// them out one at a time on the result stream.
// ----------------------------------------------------------------------------
module ucd_rsp_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  ucd_pkg::push_type        push,
   output logic                     space_ok,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output ucd_pkg::rsp_entry_type   head
);

   localparam int DEPTH = ucd_pkg::QUEUE_DEPTH;
   localparam int CNT_W = ucd_pkg::QUEUE_CNT_W;

   ucd_pkg::rsp_entry_type q_ff [DEPTH];
   ucd_pkg::rsp_entry_type q_in [DEPTH];
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       base;
   logic                   pop;

   assign rsp_tvalid = (count_ff != '0);
   assign head       = q_ff[0];
   assign pop        = rsp_tvalid && rsp_tready;
   assign space_ok   = (count_ff <= CNT_W'(DEPTH - 2));

   // Shift out the word taken this cycle, then append the new words.
   always_comb begin
      base = count_ff - CNT_W'(pop);
      for (int i = 0; i < DEPTH - 1; i++) begin
         q_in[i] = pop ? q_ff[i + 1] : q_ff[i];
      end
      q_in[DEPTH-1] = q_ff[DEPTH-1];
      for (int i = 0; i < DEPTH; i++) begin
         if ((push.count != 2'd0) && (CNT_W'(i) == base)) begin
            q_in[i] = push.first;
         end
         if ((push.count == 2'd2) && (CNT_W'(i) == base + CNT_W'(1))) begin
            q_in[i] = push.second;
         end
      end
      count_in = base + CNT_W'(push.count);
   end

   // Fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Queue words.
   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   // Words arrive only while two entries are free, so the queue never overflows.
   a_push_space: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> space_ok)
      else $error("result words pushed without room");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("result queue fill level out of range");

endmodule

### test/utf8_decode_checker.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder checker
// Watches the byte and code point streams of the UTF-8 decoder. Every byte
// word accepted on the request side is run through a predictor of the
// lenient decode, and the code points it should give are queued. Every
// response word is compared field by field with the oldest queued code point.
// ----------------------------------------------------------------------------
module utf8_decode_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] byte_in
   input  logic                           req_tlast,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [ucd_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [20:0] code_point, rest zero
   input  logic                           rsp_tlast,
   output int                             failures,
   output int                             pending
);

   // Code points still owed by the decoder, oldest first.
   ucd_pkg::rsp_entry_type cp_expected[$];
   // Code points that the byte under prediction gives.
   ucd_pkg::rsp_entry_type byte_words[$];

   // Predictor copy of the pending sequence.
   logic [ucd_pkg::BYTE_W-1:0] held_seq [0:2];
   int unsigned                held_num;
   int unsigned                trail_left;

   // Number of bytes that a byte announces when it stands as a lead; 0 if none.
   function automatic int unsigned lead_span(input logic [ucd_pkg::BYTE_W-1:0] b);
      int unsigned span;
      casez (b)
         8'b0???????: span = 1;
         8'b110?????: span = 2;
         8'b1110????: span = 3;
         8'b11110???: span = 4;
         default:     span = 0;
      endcase
      return span;
   endfunction

   // Join span bytes starting at first into a code point. Trailing bytes
   // give their low six bits whatever their top bits are.
   function automatic logic [ucd_pkg::CP_W-1:0] join_cp(
      input logic [3:0][ucd_pkg::BYTE_W-1:0] seq,
      input int unsigned                     first,
      input int unsigned                     span);
      logic [ucd_pkg::CP_W-1:0] cp;
      int unsigned              k;
      case (span)
         1:       cp = ucd_pkg::CP_W'(seq[first]);
         2:       cp = ucd_pkg::CP_W'(seq[first] & 8'h1F);
         3:       cp = ucd_pkg::CP_W'(seq[first] & 8'h0F);
         default: cp = ucd_pkg::CP_W'(seq[first] & 8'h07);
      endcase
      for (k = 1; k < span; k++) begin
         cp = {cp[ucd_pkg::CP_W-7:0], seq[first + k][5:0]};
      end
      return cp;
   endfunction

   // Queue a code point for this byte unless it is a filtered control
   // character; one byte never gives more than two words.
   task automatic offer_cp(input logic [ucd_pkg::CP_W-1:0] cp);
      ucd_pkg::rsp_entry_type w;
      if (byte_words.size() < 2 &&
          (cp >= ucd_pkg::CP_MIN_PRINT || cp == ucd_pkg::CP_TAB)) begin
         w.code_point = cp;
         w.run_last   = 1'b0;
         byte_words.insert(byte_words.size(), w);
      end
   endtask

   // Advance the predictor by one byte and queue the code points it gives.
   task automatic predict_code_points(input logic [ucd_pkg::BYTE_W-1:0] b,
                                      input logic buf_end);
      logic [3:0][ucd_pkg::BYTE_W-1:0] seq;
      int unsigned                     span;
      int unsigned                     hc;
      int unsigned                     pos;
      int unsigned                     k;
      ucd_pkg::rsp_entry_type          w;
      byte_words.delete();
      seq = '0;
      if (trail_left == 0) begin
         // A lead is expected: plain ASCII goes out, a multi-byte lead is held
         // unless the buffer ends on it, anything else is skipped.
         span = lead_span(b);
         if (span == 1) begin
            offer_cp(ucd_pkg::CP_W'(b));
         end else if (span >= 2 && !buf_end) begin
            held_seq[0] = b;
            held_num    = 1;
            trail_left  = span - 1;
         end
      end else begin
         hc = held_num;
         for (k = 0; k < hc; k++) begin
            seq[k] = held_seq[k];
         end
         seq[hc] = b;
         if (trail_left == 1) begin
            // The sequence is complete.
            held_num   = 0;
            trail_left = 0;
            offer_cp(join_cp(seq, 0, hc + 1));
         end else if (buf_end) begin
            // The buffer ends mid-sequence: drop the lead and decode the rest
            // again as a short buffer.
            held_num   = 0;
            trail_left = 0;
            pos = 1;
            while (pos <= hc) begin
               span = lead_span(seq[pos]);
               if (span != 0 && pos + span <= hc + 1) begin
                  offer_cp(join_cp(seq, pos, span));
                  pos += span;
               end else begin
                  pos++;
               end
            end
         end else begin
            held_seq[hc] = b;
            held_num     = hc + 1;
            trail_left   = trail_left - 1;
         end
      end
      // The last word that a byte gives carries the last flag.
      if (byte_words.size() > 0) begin
         w = byte_words[byte_words.size() - 1];
         w.run_last = 1'b1;
         byte_words[byte_words.size() - 1] = w;
      end
      foreach (byte_words[i]) begin
         cp_expected.insert(cp_expected.size(), byte_words[i]);
      end
   endtask

   // Compare response words first, then predict from the accepted byte.
   always @(posedge clock) begin
      ucd_pkg::rsp_entry_type want;
      if (reset) begin
         cp_expected.delete();
         held_num   = 0;
         trail_left = 0;
         failures   = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (cp_expected.size() == 0) begin
               failures++;
               $display("%0t: unexpected word: expected none, actual code_point=%h last=%b",
                        $time, rsp_tdata, rsp_tlast);
            end else begin
               want = cp_expected.pop_front();
               if (rsp_tdata !== {{(ucd_pkg::RSP_DATA_W-ucd_pkg::CP_W){1'b0}},
                                  want.code_point}) begin
                  failures++;
                  $display("%0t: code_point mismatch: expected %h, actual %h",
                           $time, want.code_point, rsp_tdata);
               end
               if (rsp_tlast !== want.run_last) begin
                  failures++;
                  $display("%0t: last flag mismatch: expected %b, actual %b",
                           $time, want.run_last, rsp_tlast);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_code_points(req_tdata, req_tlast);
         end
      end
      pending = cp_expected.size();
   end

endmodule

### test/utf8_to_codepoint_decoder_top_test.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder testbench
// Drives byte words into the UTF-8 to code point decoder, first a directed
// set of corner cases, then random sequences that are mostly well formed,
// with truncated buffers and noise mixed in. Both sides idle in random
// bursts; the receiver also holds off for a long stretch once, and the
// sender pauses once until the decoder has drained. A separate checker
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module utf8_to_codepoint_decoder_top_test;

   localparam int ITEM_COUNT   = 900;
   localparam int CALM_TAIL    = 150;
   localparam int HOLD_AT      = 300;
   localparam int PAUSE_AT     = 550;
   localparam int LONG_HOLD    = 64;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [7:0]                     req_tdata;   // [7:0] byte_in
   logic                           req_tlast;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [ucd_pkg::RSP_DATA_W-1:0] rsp_tdata;   // [20:0] code_point, rest zero
   logic                           rsp_tlast;

   int          failures;
   int          pending;
   bit          bursts_on;
   bit          hold_req;
   bit          hold_done;
   bit          pause_done;
   int unsigned bytes_sent;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   utf8_to_codepoint_decoder_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   utf8_decode_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .failures   (failures),
      .pending    (pending)
   );

   // Offer one byte word, with a random idle burst ahead of it, and return
   // at the edge where it is accepted. Ready is sampled at the falling edge.
   task automatic send_byte(input logic [7:0] b, input logic buf_end);
      if (bursts_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= buf_end;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      bytes_sent++;
   endtask

   // Random lead byte for a sequence of the given length.
   function automatic logic [7:0] random_lead(input int unsigned span);
      logic [7:0] r;
      r = 8'($urandom);
      case (span)
         1:       r[7]   = 1'b0;
         2:       r[7:5] = 3'b110;
         3:       r[7:4] = 4'b1110;
         default: r[7:3] = 5'b11110;
      endcase
      return r;
   endfunction

   // Random continuation byte.
   function automatic logic [7:0] random_trail();
      logic [7:0] r;
      r = 8'($urandom);
      r[7:6] = 2'b10;
      return r;
   endfunction

   // One random stretch of bytes: mostly well-formed sequences, some buffers
   // cut short mid-sequence with arbitrary trailing content, and some noise.
   task automatic send_random_run();
      int unsigned pick;
      int unsigned span;
      int unsigned cut;
      int unsigned k;
      logic [7:0]  b;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         span = $urandom_range(1, 4);
         send_byte(random_lead(span), $urandom_range(0, 15) == 0);
         for (k = 1; k < span; k++) begin
            send_byte(random_trail(), $urandom_range(0, 15) == 0);
         end
      end else if (pick < 85) begin
         span = $urandom_range(2, 4);
         cut  = $urandom_range(1, span - 1);
         send_byte(random_lead(span), 1'b0);
         for (k = 1; k <= cut; k++) begin
            case ($urandom_range(0, 2))
               0:       b = random_trail();
               1:       b = random_lead(1);
               default: b = 8'($urandom);
            endcase
            send_byte(b, k == cut);
         end
      end else begin
         send_byte(8'($urandom), $urandom_range(0, 7) == 0);
      end
   endtask

   // Receiver: ready drops in random bursts, and once for a long hold-off.
   initial begin : rsp_side
      int unsigned stall_left;
      rsp_tready = 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
         end else if (hold_req) begin
            rsp_tready <= 1'b0;
            stall_left = LONG_HOLD;
            hold_req   = 1'b0;
         end else if (bursts_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(0, 3);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: ends the run when no word moves on either side for too long.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(negedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // Stimulus and verdict.
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      bursts_on  = 1'b1;
      hold_req   = 1'b0;
      hold_done  = 1'b0;
      pause_done = 1'b0;
      bytes_sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // ASCII, tab, filtered controls and the top ASCII code.
      send_byte(8'h41, 1'b0);
      send_byte(8'h09, 1'b0);
      send_byte(8'h0A, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b0);
      // Stray continuation and a byte that is never a lead.
      send_byte(8'h80, 1'b0);
      send_byte(8'hF8, 1'b0);
      // Well-formed two, three and four byte sequences, the last one maximal.
      send_byte(8'hC3, 1'b0);
      send_byte(8'hA9, 1'b0);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'hAC, 1'b0);
      send_byte(8'hF7, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      // Lead that is itself the last byte of a buffer.
      send_byte(8'hC2, 1'b1);
      // Overlong sequence that decodes to a filtered control character.
      send_byte(8'hC0, 1'b0);
      send_byte(8'h81, 1'b0);
      // Buffer ends mid-sequence and the held bytes decode to two words.
      send_byte(8'hF0, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b1);
      // Buffer ends mid-sequence and the replay is filtered away.
      send_byte(8'hE2, 1'b0);
      send_byte(8'h01, 1'b1);
      // ASCII byte taken as a trailing byte.
      send_byte(8'hC3, 1'b0);
      send_byte(8'h41, 1'b0);

      while (bytes_sent < ITEM_COUNT) begin
         if (!hold_done && bytes_sent >= HOLD_AT) begin
            hold_req  = 1'b1;
            hold_done = 1'b1;
         end
         if (!pause_done && bytes_sent >= PAUSE_AT) begin
            // Let the decoder drain completely before going on.
            req_tvalid <= 1'b0;
            @(posedge clock);
            wait (pending == 0);
            @(posedge clock);
            pause_done = 1'b1;
         end
         if (bytes_sent >= ITEM_COUNT - CALM_TAIL) begin
            bursts_on = 1'b0;
         end
         send_random_run();
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
